[src/csvp_pkg.sv]
// shared types, constants and helpers for the csv byte stream parser
// no dependencies
package csvp_pkg;

  localparam int CntW = 32;

  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [2:0] {
    EV_FIELD_CHAR   = 3'd0,
    EV_COMMENT_CHAR = 3'd1,
    EV_END_FIELD    = 3'd2,
    EV_END_LINE     = 3'd3,
    EV_END_COMMENT  = 3'd4,
    EV_ERROR        = 3'd5,
    EV_END_FILE     = 3'd6
  } event_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_MALFORMED  = 2'd1,
    ERR_UNTERM     = 2'd2,
    ERR_EMPTY_FILE = 2'd3
  } err_code_t;

  typedef enum logic [1:0] {
    REG_SEPARATOR = 2'd0,
    REG_QUOTE     = 2'd1,
    REG_COMMENT   = 2'd2,
    REG_NEWLINE   = 2'd3
  } reg_index_t;

  localparam logic [7:0] SeparatorReset = 8'd44;
  localparam logic [7:0] QuoteReset     = 8'd34;
  localparam logic [7:0] CommentReset   = 8'd35;
  localparam logic [7:0] NewlineReset   = 8'd10;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic [7:0]  char_out;
    err_code_t   error_code;
    logic [31:0] line_number;
    logic [31:0] byte_position;
    logic        last;
  } out_item_t;

  // one result of a transaction, without the shared counter values
  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  ch;
    err_code_t   err;
  } ev_t;

  // all results caused by one input transaction
  typedef struct packed {
    logic [1:0]    n;
    ev_t [2:0]     ev;
    logic [31:0]   line_number;
    logic [31:0]   byte_position;
  } grp_t;

  function automatic ev_t mk_ev(event_kind_t kind, logic [7:0] ch, err_code_t err);
    ev_t e;
    e.kind = kind;
    e.ch   = ch;
    e.err  = err;
    return e;
  endfunction

  function automatic logic [31:0] sat32(cnt_t c);
    logic [63:0] wide;
    wide = 64'(c);
    if (wide > 64'h0000_0000_FFFF_FFFF) begin
      return '1;
    end
    return 32'(c);
  endfunction

endpackage

[src/csvp_parse.sv]
// input register, parse state machine, counters and configuration registers
// depends on csvp_pkg
module csvp_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  csvp_pkg::in_item_t byte_item,
  input  logic               take,
  output logic               grp_load,
  output csvp_pkg::grp_t     grp
);

  typedef enum logic [2:0] {
    ST_INITIAL      = 3'd0,
    ST_COMMENT      = 3'd1,
    ST_RECORD       = 3'd2,
    ST_QUOTED       = 3'd3,
    ST_QUOTE_QUOTED = 3'd4,
    ST_NEW_LINE     = 3'd5,
    ST_BETWEEN      = 3'd6
  } state_t;

  state_t             state, state_next;
  csvp_pkg::cnt_t     line_count, line_count_next;
  csvp_pkg::cnt_t     byte_count, byte_count_next;
  logic               error_seen, error_seen_next;
  logic [7:0]         separator_char, quote_char, comment_char, newline_char;
  logic               item_valid;
  csvp_pkg::in_item_t item;

  logic       is_sep, is_quote, is_comment, is_nl;
  logic [7:0] c;

  assign grp_load   = item_valid && take;
  assign byte_stall = item_valid && !take;

  assign c          = item.data_byte;
  assign is_sep     = (c == separator_char);
  assign is_quote   = (c == quote_char);
  assign is_comment = (c == comment_char);
  assign is_nl      = (c == newline_char);

  always_comb begin
    state_next      = state;
    line_count_next = line_count;
    byte_count_next = byte_count;
    error_seen_next = error_seen;
    grp.n           = 2'd0;
    grp.ev[0] = csvp_pkg::mk_ev(csvp_pkg::EV_FIELD_CHAR, 8'd0, csvp_pkg::ERR_NONE);
    grp.ev[1] = grp.ev[0];
    grp.ev[2] = grp.ev[0];

    if (item.command) begin
      // end of data: flush what is open, then end of file unless an error stands
      case (state)
        ST_QUOTE_QUOTED, ST_RECORD, ST_BETWEEN: begin
          grp.ev[0] = csvp_pkg::mk_ev(csvp_pkg::EV_END_FIELD, 8'd0, csvp_pkg::ERR_NONE);
          grp.ev[1] = csvp_pkg::mk_ev(csvp_pkg::EV_END_LINE, 8'd0, csvp_pkg::ERR_NONE);
          grp.ev[2] = csvp_pkg::mk_ev(csvp_pkg::EV_END_FILE, 8'd0, csvp_pkg::ERR_NONE);
          grp.n     = error_seen ? 2'd2 : 2'd3;
        end
        ST_QUOTED: begin
          grp.ev[0] = csvp_pkg::mk_ev(csvp_pkg::EV_ERROR, 8'd0, csvp_pkg::ERR_UNTERM);
          grp.n     = 2'd1;
          error_seen_next = 1'b1;
        end
        ST_COMMENT: begin
          grp.ev[0] = csvp_pkg::mk_ev(csvp_pkg::EV_END_COMMENT, 8'd0, csvp_pkg::ERR_NONE);
          grp.ev[1] = csvp_pkg::mk_ev(csvp_pkg::EV_END_FILE, 8'd0, csvp_pkg::ERR_NONE);
          grp.n     = error_seen ? 2'd1 : 2'd2;
        end
        ST_INITIAL: begin
          grp.ev[0] = csvp_pkg::mk_ev(csvp_pkg::EV_ERROR, 8'd0, csvp_pkg::ERR_EMPTY_FILE);
          grp.n     = 2'd1;
          error_seen_next = 1'b1;
        end
        default: begin
          grp.ev[0] = csvp_pkg::mk_ev(csvp_pkg::EV_END_FILE, 8'd0, csvp_pkg::ERR_NONE);
          grp.n     = error_seen ? 2'd0 : 2'd1;
        end
      endcase
    end else if (!error_seen) begin
      if (byte_count != '1) begin
        byte_count_next = byte_count + 1'b1;
      end
      if (is_nl && line_count != '1) begin
        line_count_next = line_count + 1'b1;
      end
      case (state)
        ST_INITIAL, ST_NEW_LINE, ST_BETWEEN: begin
          if (is_sep) begin
            grp.ev[0]  = csvp_pkg::mk_ev(csvp_pkg::EV_END_FIELD, 8'd0, csvp_pkg::ERR_NONE);
            grp.n      = 2'd1;
            state_next = ST_BETWEEN;
          end else if (is_quote) begin
            state_next = ST_QUOTED;
          end else if (state != ST_BETWEEN && is_comment) begin
            state_next = ST_COMMENT;
          end else if (is_nl) begin
            if (state == ST_BETWEEN) begin
              grp.ev[0] = csvp_pkg::mk_ev(csvp_pkg::EV_END_FIELD, 8'd0, csvp_pkg::ERR_NONE);
              grp.ev[1] = csvp_pkg::mk_ev(csvp_pkg::EV_END_LINE, 8'd0, csvp_pkg::ERR_NONE);
              grp.n     = 2'd2;
            end else begin
              grp.ev[0] = csvp_pkg::mk_ev(csvp_pkg::EV_END_LINE, 8'd0, csvp_pkg::ERR_NONE);
              grp.n     = 2'd1;
            end
            state_next = ST_NEW_LINE;
          end else begin
            grp.ev[0]  = csvp_pkg::mk_ev(csvp_pkg::EV_FIELD_CHAR, c, csvp_pkg::ERR_NONE);
            grp.n      = 2'd1;
            state_next = ST_RECORD;
          end
        end
        ST_RECORD: begin
          if (is_sep) begin
            grp.ev[0]  = csvp_pkg::mk_ev(csvp_pkg::EV_END_FIELD, 8'd0, csvp_pkg::ERR_NONE);
            grp.n      = 2'd1;
            state_next = ST_BETWEEN;
          end else if (is_nl) begin
            grp.ev[0]  = csvp_pkg::mk_ev(csvp_pkg::EV_END_FIELD, 8'd0, csvp_pkg::ERR_NONE);
            grp.ev[1]  = csvp_pkg::mk_ev(csvp_pkg::EV_END_LINE, 8'd0, csvp_pkg::ERR_NONE);
            grp.n      = 2'd2;
            state_next = ST_NEW_LINE;
          end else begin
            grp.ev[0] = csvp_pkg::mk_ev(csvp_pkg::EV_FIELD_CHAR, c, csvp_pkg::ERR_NONE);
            grp.n     = 2'd1;
          end
        end
        ST_QUOTED: begin
          if (is_quote) begin
            state_next = ST_QUOTE_QUOTED;
          end else begin
            grp.ev[0] = csvp_pkg::mk_ev(csvp_pkg::EV_FIELD_CHAR, c, csvp_pkg::ERR_NONE);
            grp.n     = 2'd1;
          end
        end
        ST_QUOTE_QUOTED: begin
          if (is_sep) begin
            grp.ev[0]  = csvp_pkg::mk_ev(csvp_pkg::EV_END_FIELD, 8'd0, csvp_pkg::ERR_NONE);
            grp.n      = 2'd1;
            state_next = ST_BETWEEN;
          end else if (is_quote) begin
            // doubled quote stands for one literal quote
            grp.ev[0]  = csvp_pkg::mk_ev(csvp_pkg::EV_FIELD_CHAR, c, csvp_pkg::ERR_NONE);
            grp.n      = 2'd1;
            state_next = ST_QUOTED;
          end else if (is_nl) begin
            grp.ev[0]  = csvp_pkg::mk_ev(csvp_pkg::EV_END_FIELD, 8'd0, csvp_pkg::ERR_NONE);
            grp.ev[1]  = csvp_pkg::mk_ev(csvp_pkg::EV_END_LINE, 8'd0, csvp_pkg::ERR_NONE);
            grp.n      = 2'd2;
            state_next = ST_NEW_LINE;
          end else begin
            grp.ev[0] = csvp_pkg::mk_ev(csvp_pkg::EV_ERROR, 8'd0, csvp_pkg::ERR_MALFORMED);
            grp.n     = 2'd1;
            error_seen_next = 1'b1;
          end
        end
        ST_COMMENT: begin
          if (is_nl) begin
            grp.ev[0]  = csvp_pkg::mk_ev(csvp_pkg::EV_END_COMMENT, 8'd0, csvp_pkg::ERR_NONE);
            grp.n      = 2'd1;
            state_next = ST_NEW_LINE;
          end else begin
            grp.ev[0] = csvp_pkg::mk_ev(csvp_pkg::EV_COMMENT_CHAR, c, csvp_pkg::ERR_NONE);
            grp.n     = 2'd1;
          end
        end
        default: begin
          state_next = ST_INITIAL;
        end
      endcase
    end

    // line before this byte is counted, position after
    grp.line_number   = csvp_pkg::sat32(line_count);
    grp.byte_position = csvp_pkg::sat32(byte_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_INITIAL;
      line_count     <= '0;
      byte_count     <= '0;
      error_seen     <= 1'b0;
      item_valid     <= 1'b0;
      separator_char <= csvp_pkg::SeparatorReset;
      quote_char     <= csvp_pkg::QuoteReset;
      comment_char   <= csvp_pkg::CommentReset;
      newline_char   <= csvp_pkg::NewlineReset;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          csvp_pkg::REG_SEPARATOR: separator_char <= cfg_data;
          csvp_pkg::REG_QUOTE:     quote_char     <= cfg_data;
          csvp_pkg::REG_COMMENT:   comment_char   <= cfg_data;
          csvp_pkg::REG_NEWLINE:   newline_char   <= cfg_data;
          default: ;
        endcase
      end
      if (grp_load) begin
        state      <= state_next;
        line_count <= line_count_next;
        byte_count <= byte_count_next;
        error_seen <= error_seen_next;
      end
      if (!byte_stall) begin
        item_valid <= byte_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      item <= byte_item;
    end
  end

endmodule

[src/csvp_outq.sv]
// result register: holds one transaction's results, sends one per unstalled cycle
// depends on csvp_pkg
module csvp_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                grp_load,
  input  csvp_pkg::grp_t      grp,
  output logic                take,
  output logic                event_valid,
  input  logic                event_stall,
  output csvp_pkg::out_item_t event_item
);

  logic [1:0]     count;
  logic [1:0]     idx;
  csvp_pkg::grp_t held;
  logic           is_last;
  logic           sent;

  assign event_valid = (count != 2'd0);
  assign is_last     = (idx == count - 2'd1);
  assign sent        = event_valid && !event_stall;
  assign take        = !event_valid || (sent && is_last);

  always_comb begin
    event_item.event_kind    = held.ev[idx].kind;
    event_item.char_out      = held.ev[idx].ch;
    event_item.error_code    = held.ev[idx].err;
    event_item.line_number   = held.line_number;
    event_item.byte_position = held.byte_position;
    event_item.last          = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      idx   <= 2'd0;
    end else if (grp_load) begin
      count <= grp.n;
      idx   <= 2'd0;
    end else if (sent) begin
      // last event gone with nothing new to load: register goes empty
      if (is_last) begin
        count <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_load) begin
      held <= grp;
    end
  end

endmodule

[src/csv_byte_stream_parser.sv]
// top level of the csv byte stream parser
// depends on csvp_pkg, csvp_parse and csvp_outq
//
// Input channel (byte_valid / byte_stall / byte_item): one transaction per
// cycle, unless stalled, carries a data byte, or the end-of-data command.
// Output channel (event_valid / event_stall / event_item): up to three parse
// events per transaction, last set on the final event of an input transaction.
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (separator, quote, comment, newline); write only while the block is idle.
// Path: an accepted input lands in the input register, is parsed from there
// and, once the result register takes it, its events leave that register.
// Throughput: one input per cycle while each input yields at most one event
// and the output does not stall; an input with two or three events holds
// the result register until all are sent, one event per unstalled cycle;
// inputs without events (opening quote, byte dropped after an error) skip it.
// Reset: state to initial, counters and error flag to zero, registers to
// comma, double quote, hash and line feed. A stalled output holds its event
// steady and, once the input register fills, stalls the input.
module csv_byte_stream_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  csvp_pkg::in_item_t  byte_item,
  output logic                event_valid,
  input  logic                event_stall,
  output csvp_pkg::out_item_t event_item
);

  logic           take;
  logic           grp_load;
  csvp_pkg::grp_t grp;

  csvp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .take       (take),
    .grp_load   (grp_load),
    .grp        (grp)
  );

  csvp_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .grp_load    (grp_load),
    .grp         (grp),
    .take        (take),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_item  (event_item)
  );

endmodule

[verif/csv_byte_stream_parser_tb.sv]
// self-checking testbench for csv_byte_stream_parser: directed and random csv text
// against an in-bench parser model. depends on csvp_pkg and the parser rtl
`timescale 1ns / 100ps

module testbench;

  typedef enum logic [2:0] {
    PS_INITIAL,
    PS_COMMENT,
    PS_RECORD,
    PS_QUOTED,
    PS_QUOTE_QUOTED,
    PS_NEW_LINE,
    PS_BETWEEN
  } parse_state_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = csvp_pkg::REG_SEPARATOR;
  logic [7:0]          cfg_data = 8'h00;
  logic                byte_valid = 1'b0;
  logic                byte_stall;
  csvp_pkg::in_item_t  byte_item = '0;
  logic                event_valid;
  logic                event_stall = 1'b0;
  csvp_pkg::out_item_t event_item;

  // parser model state, updated when a transaction is accepted
  logic [7:0]   sep_chr = csvp_pkg::SeparatorReset;
  logic [7:0]   quote_chr = csvp_pkg::QuoteReset;
  logic [7:0]   comment_chr = csvp_pkg::CommentReset;
  logic [7:0]   newline_chr = csvp_pkg::NewlineReset;
  parse_state_t pstate = PS_INITIAL;
  logic [31:0]  line_cnt = '0;
  logic [31:0]  byte_cnt = '0;
  logic         err_flag = 1'b0;

  csvp_pkg::out_item_t expected_events[$];
  csvp_pkg::out_item_t step_events[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b0;

  csv_byte_stream_parser dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_item   (byte_item),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_item  (event_item)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  function automatic void add_event(csvp_pkg::event_kind_t kind, logic [7:0] ch,
                                    csvp_pkg::err_code_t err);
    csvp_pkg::out_item_t ev;
    ev.event_kind    = kind;
    ev.char_out      = ch;
    ev.error_code    = err;
    ev.line_number   = line_cnt;
    ev.byte_position = byte_cnt;
    ev.last          = 1'b0;
    if (step_events.size() < 3) step_events = {step_events, ev};
  endfunction

  function automatic void parse_byte(logic [7:0] c);
    logic is_sep, is_quote, is_nl;
    is_sep   = (c == sep_chr);
    is_quote = (c == quote_chr);
    is_nl    = (c == newline_chr);
    case (pstate)
      PS_INITIAL, PS_NEW_LINE, PS_BETWEEN: begin
        if (is_sep) begin
          add_event(csvp_pkg::EV_END_FIELD, 8'h00, csvp_pkg::ERR_NONE);
          pstate = PS_BETWEEN;
        end else if (is_quote) begin
          pstate = PS_QUOTED;
        end else if (pstate != PS_BETWEEN && c == comment_chr) begin
          pstate = PS_COMMENT;
        end else if (is_nl) begin
          if (pstate == PS_BETWEEN)
            add_event(csvp_pkg::EV_END_FIELD, 8'h00, csvp_pkg::ERR_NONE);
          add_event(csvp_pkg::EV_END_LINE, 8'h00, csvp_pkg::ERR_NONE);
          pstate = PS_NEW_LINE;
        end else begin
          add_event(csvp_pkg::EV_FIELD_CHAR, c, csvp_pkg::ERR_NONE);
          pstate = PS_RECORD;
        end
      end
      PS_RECORD: begin
        if (is_sep) begin
          add_event(csvp_pkg::EV_END_FIELD, 8'h00, csvp_pkg::ERR_NONE);
          pstate = PS_BETWEEN;
        end else if (is_nl) begin
          add_event(csvp_pkg::EV_END_FIELD, 8'h00, csvp_pkg::ERR_NONE);
          add_event(csvp_pkg::EV_END_LINE, 8'h00, csvp_pkg::ERR_NONE);
          pstate = PS_NEW_LINE;
        end else begin
          add_event(csvp_pkg::EV_FIELD_CHAR, c, csvp_pkg::ERR_NONE);
        end
      end
      PS_QUOTED: begin
        if (is_quote) pstate = PS_QUOTE_QUOTED;
        else add_event(csvp_pkg::EV_FIELD_CHAR, c, csvp_pkg::ERR_NONE);
      end
      PS_QUOTE_QUOTED: begin
        if (is_sep) begin
          add_event(csvp_pkg::EV_END_FIELD, 8'h00, csvp_pkg::ERR_NONE);
          pstate = PS_BETWEEN;
        end else if (is_quote) begin
          // doubled quote stands for one literal quote
          add_event(csvp_pkg::EV_FIELD_CHAR, c, csvp_pkg::ERR_NONE);
          pstate = PS_QUOTED;
        end else if (is_nl) begin
          add_event(csvp_pkg::EV_END_FIELD, 8'h00, csvp_pkg::ERR_NONE);
          add_event(csvp_pkg::EV_END_LINE, 8'h00, csvp_pkg::ERR_NONE);
          pstate = PS_NEW_LINE;
        end else begin
          add_event(csvp_pkg::EV_ERROR, 8'h00, csvp_pkg::ERR_MALFORMED);
          err_flag = 1'b1;
        end
      end
      PS_COMMENT: begin
        if (is_nl) begin
          add_event(csvp_pkg::EV_END_COMMENT, 8'h00, csvp_pkg::ERR_NONE);
          pstate = PS_NEW_LINE;
        end else begin
          add_event(csvp_pkg::EV_COMMENT_CHAR, c, csvp_pkg::ERR_NONE);
        end
      end
      default: pstate = PS_INITIAL;
    endcase
    // newline counts after its events, wherever it sits
    if (is_nl && line_cnt != '1) line_cnt++;
  endfunction

  function automatic void flush_at_end();
    case (pstate)
      PS_QUOTE_QUOTED, PS_RECORD, PS_BETWEEN: begin
        add_event(csvp_pkg::EV_END_FIELD, 8'h00, csvp_pkg::ERR_NONE);
        add_event(csvp_pkg::EV_END_LINE, 8'h00, csvp_pkg::ERR_NONE);
      end
      PS_QUOTED: begin
        add_event(csvp_pkg::EV_ERROR, 8'h00, csvp_pkg::ERR_UNTERM);
        err_flag = 1'b1;
      end
      PS_COMMENT: add_event(csvp_pkg::EV_END_COMMENT, 8'h00, csvp_pkg::ERR_NONE);
      PS_INITIAL: begin
        add_event(csvp_pkg::EV_ERROR, 8'h00, csvp_pkg::ERR_EMPTY_FILE);
        err_flag = 1'b1;
      end
      default: ;
    endcase
    if (!err_flag) add_event(csvp_pkg::EV_END_FILE, 8'h00, csvp_pkg::ERR_NONE);
  endfunction

  function automatic void predict_events(csvp_pkg::in_item_t it);
    step_events.delete();
    if (it.command) begin
      flush_at_end();
    end else if (!err_flag) begin
      if (byte_cnt != '1) byte_cnt++;
      parse_byte(it.data_byte);
    end
    if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
    foreach (step_events[i]) expected_events = {expected_events, step_events[i]};
  endfunction

  // one input transaction; the sender runs in bursts, with random gaps when gaps_on is set
  task automatic send_item(input logic cmd, input logic [7:0] b);
    csvp_pkg::in_item_t it;
    it.command   = cmd;
    it.data_byte = b;
    byte_valid <= 1'b1;
    byte_item  <= it;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    predict_events(it);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if (gaps_on) begin
        byte_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
  endtask

  task automatic send_end();
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // keeps random text clear of a malformed quote until the final test
  task automatic send_byte(input logic [7:0] b);
    logic [7:0] pick;
    pick = b;
    if (pstate == PS_QUOTE_QUOTED && pick != sep_chr && pick != quote_chr &&
        pick != newline_chr) begin
      case ($urandom_range(0, 2))
        0:       pick = sep_chr;
        1:       pick = quote_chr;
        default: pick = newline_chr;
      endcase
    end
    send_item(1'b0, pick);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  task automatic wait_idle(input int extra);
    byte_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    // bytes without events may still be in flight
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input csvp_pkg::reg_index_t idx, input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    case (idx)
      csvp_pkg::REG_SEPARATOR: sep_chr = v;
      csvp_pkg::REG_QUOTE:     quote_chr = v;
      csvp_pkg::REG_COMMENT:   comment_chr = v;
      csvp_pkg::REG_NEWLINE:   newline_chr = v;
      default: ;
    endcase
  endtask

  task automatic set_delimiters(input logic [7:0] s, input logic [7:0] q,
                                input logic [7:0] c, input logic [7:0] n);
    wait_idle(6);
    write_reg(csvp_pkg::REG_SEPARATOR, s);
    write_reg(csvp_pkg::REG_QUOTE, q);
    write_reg(csvp_pkg::REG_COMMENT, c);
    write_reg(csvp_pkg::REG_NEWLINE, n);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] text_char();
    if ($urandom_range(0, 9) < 4) begin
      case ($urandom_range(0, 3))
        0:       return sep_chr;
        1:       return quote_chr;
        2:       return comment_chr;
        default: return newline_chr;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // a comment line, some noise, an end of data, or a record of mixed fields
  task automatic send_random_line();
    int kind_sel, nfields;
    kind_sel = $urandom_range(0, 9);
    if (kind_sel == 0) begin
      send_byte(comment_chr);
      repeat ($urandom_range(0, 6)) send_byte(text_char());
      send_byte(newline_chr);
    end else if (kind_sel == 1) begin
      repeat ($urandom_range(1, 8)) send_byte(text_char());
    end else if (kind_sel == 2) begin
      if (pstate != PS_QUOTED && pstate != PS_INITIAL) send_end();
    end else begin
      nfields = $urandom_range(1, 4);
      for (int f = 0; f < nfields; f++) begin
        if (f > 0) send_byte(sep_chr);
        case ($urandom_range(0, 3))
          0: ;
          3: begin
            send_byte(quote_chr);
            repeat ($urandom_range(0, 5)) begin
              case ($urandom_range(0, 5))
                0: begin
                  send_byte(quote_chr);
                  send_byte(quote_chr);
                end
                1:       send_byte(sep_chr);
                2:       send_byte(newline_chr);
                default: send_byte(text_char());
              endcase
            end
            send_byte(quote_chr);
          end
          default: repeat ($urandom_range(1, 5)) send_byte(text_char());
        endcase
      end
      send_byte(newline_chr);
    end
  endtask

  task automatic run_text_phase(input logic [7:0] s, input logic [7:0] q,
                                input logic [7:0] c, input logic [7:0] n,
                                input bit gaps, input int unsigned count);
    int unsigned start;
    set_delimiters(s, q, c, n);
    gaps_on = gaps;
    start = items_sent;
    while (items_sent - start < count) send_random_line();
  endtask

  // reset delimiters: quoted fields, doubled quotes, comments, end of data twice in a row and again after a newline
  task automatic test_default_directed();
    gaps_on = 1'b1;
    send_text("a,\"x\"\"\n\",\n#c,\n\"\"\nq\",#");
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_end();
    send_end();
    send_text("\n");
    send_end();
  endtask

  // shared delimiter values resolve as separator, quote, comment, newline
  task automatic test_delimiter_priority();
    set_delimiters(8'h00, 8'h00, 8'h00, 8'h00);
    send_item(1'b0, 8'h00);
    send_text("a");
    send_item(1'b0, 8'h00);
    send_end();
    set_delimiters(8'h00, 8'hFF, 8'hFF, 8'hFF);
    repeat (4) send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    repeat (2) send_item(1'b0, 8'hFF);
    send_end();
    set_delimiters(csvp_pkg::SeparatorReset, csvp_pkg::QuoteReset,
                   csvp_pkg::NewlineReset, csvp_pkg::NewlineReset);
    send_text(",\n\nz\n");
  endtask

  task automatic test_random_text();
    logic [7:0] d [4];
    run_text_phase(csvp_pkg::SeparatorReset, csvp_pkg::QuoteReset,
                   csvp_pkg::CommentReset, csvp_pkg::NewlineReset, 1'b0, 60);
    run_text_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1, 50);
    run_text_phase(8'h00, 8'hFF, 8'h01, 8'hFE, 1'b1, 50);
    run_text_phase(8'hFF, 8'h00, 8'hFE, 8'h01, 1'b1, 40);
    foreach (d[i]) begin
      case ($urandom_range(0, 3))
        0:       d[i] = 8'h00;
        1:       d[i] = 8'hFF;
        2:       d[i] = csvp_pkg::SeparatorReset;
        default: d[i] = csvp_pkg::NewlineReset;
      endcase
    end
    run_text_phase(d[0], d[1], d[2], d[3], 1'b1, 50);
    run_text_phase(csvp_pkg::SeparatorReset, csvp_pkg::QuoteReset,
                   csvp_pkg::CommentReset, csvp_pkg::NewlineReset, 1'b1, 50);
  endtask

  // the error is sticky, so this runs last: later bytes are dropped uncounted
  task automatic test_malformed_quote_tail();
    set_delimiters(csvp_pkg::SeparatorReset, csvp_pkg::QuoteReset,
                   csvp_pkg::CommentReset, csvp_pkg::NewlineReset);
    while (pstate != PS_NEW_LINE) begin
      if (pstate == PS_QUOTED) send_item(1'b0, quote_chr);
      else send_item(1'b0, newline_chr);
    end
    send_text("\"a\"b\n,c");
    send_end();
    send_end();
  endtask

  // receiver stall pattern: modes of no stall, short stalls and long runs
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  int unsigned tick = 0;
  always @(posedge clk) begin : receiver_stall
    logic stall_now;
    tick++;
    if (tick % 300 == 0) stall_mode = $urandom_range(0, 2);
    if (stall_left == 0) begin
      case (stall_mode)
        0: begin
          stall_now  = 1'b0;
          stall_left = $urandom_range(1, 20);
        end
        1: begin
          stall_now  = ($urandom_range(0, 2) == 0);
          stall_left = $urandom_range(1, 3);
        end
        default: begin
          stall_now  = 1'($urandom_range(0, 1));
          stall_left = $urandom_range(1, 8);
        end
      endcase
      event_stall <= stall_now;
    end else begin
      stall_left--;
    end
  end

  always @(posedge clk) begin : check_events
    csvp_pkg::out_item_t want;
    if (!rst && event_valid && !event_stall) begin
      if (expected_events.size() == 0) begin
        report_mismatch("event with none expected, kind", 32'(event_item.event_kind), '0);
      end else begin
        want = expected_events.pop_front();
        if (event_item.event_kind != want.event_kind)
          report_mismatch("event_kind", 32'(event_item.event_kind), 32'(want.event_kind));
        if (event_item.char_out != want.char_out)
          report_mismatch("char_out", 32'(event_item.char_out), 32'(want.char_out));
        if (event_item.error_code != want.error_code)
          report_mismatch("error_code", 32'(event_item.error_code), 32'(want.error_code));
        if (event_item.line_number != want.line_number)
          report_mismatch("line_number", event_item.line_number, want.line_number);
        if (event_item.byte_position != want.byte_position)
          report_mismatch("byte_position", event_item.byte_position, want.byte_position);
        if (event_item.last != want.last)
          report_mismatch("last", 32'(event_item.last), 32'(want.last));
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_directed();
    test_delimiter_priority();
    test_random_text();
    test_malformed_quote_tail();
    wait_idle(10);
    if (expected_events.size() != 0) begin
      report_mismatch("events never delivered", '0, 32'(expected_events.size()));
    end
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
